// ===== hw/rtl/shift_register_pwm_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Shift register PWM generator assertion macros
// Property wrappers used by the controller to check its own logic.
// ----------------------------------------------------------------------------
`ifndef SHIFT_REGISTER_PWM_GENERATOR_DEFINES_SVH
`define SHIFT_REGISTER_PWM_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SRPWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define SRPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// srpwm_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package srpwm_pkg;

  localparam int MAX_REGISTERS_DEF = 8;

  localparam int OP_W       = 2;
  localparam int PIN_W      = 6;
  localparam int DUTY_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int REGCNT_W   = 4;
  localparam int STEP_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ROW_BITS   = 8 * BYTE_W;

  localparam logic [OP_W-1:0] OP_SET_ONE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_ALL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX  = 1'd1;

  localparam logic [REGCNT_W-1:0] REG_COUNT_RST = 4'd1;
  localparam logic [STEP_W-1:0]   STEP_MAX_RST  = 8'd255;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture pin and duty of the accepted item
    logic wr_one;     // write one duty entry
    logic wr_all;     // write a whole row of entries
    logic rd;         // read one row
    logic emit;       // compare read row and load the output byte
    logic phase_adv;  // advance the phase counter
  } srpwm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REGCNT_W-1:0] regs;    // registers in use, clamped
    logic                pin_ok;  // captured pin lies within the chain
  } srpwm_status_t;

endpackage

// ===== hw/rtl/srpwm_datapath.sv =====
// ----------------------------------------------------------------------------
// srpwm_datapath
// Configuration registers, duty store, phase counter and output byte.
// ----------------------------------------------------------------------------
module srpwm_datapath
  import srpwm_pkg::*;
#(
  parameter int MAX_REGISTERS = MAX_REGISTERS_DEF,
  parameter int ROW_W         = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIN_W-1:0]      in_pin,
  input  logic [DUTY_W-1:0]     in_duty,
  input  srpwm_cmd_t            cmd,
  input  logic [ROW_W-1:0]      row,
  output srpwm_status_t         status,
  output logic [BYTE_W-1:0]     out_byte
);

  logic [REGCNT_W-1:0] reg_count;
  logic [STEP_W-1:0]   step_max;
  logic [STEP_W-1:0]   phase;
  logic [PIN_W-1:0]    pin_q;
  logic [DUTY_W-1:0]   duty_q;

  logic [ROW_BITS-1:0] mem [MAX_REGISTERS];
  logic [7:0]          row_vld [MAX_REGISTERS];
  logic [ROW_BITS-1:0] rd_data;
  logic [7:0]          rd_vld;

  logic [REGCNT_W-1:0] regs;
  logic [ROW_W-1:0]    wr_row;
  logic [7:0]          wr_be;
  logic [BYTE_W-1:0]   byte_next;

  assign regs = (reg_count > REGCNT_W'(MAX_REGISTERS)) ? REGCNT_W'(MAX_REGISTERS)
                                                        : reg_count;
  assign status.regs   = regs;
  assign status.pin_ok = ({1'b0, pin_q[5:3]} < regs);

  assign wr_row = cmd.wr_one ? ROW_W'(pin_q[5:3]) : row;
  always_comb begin
    wr_be = '0;
    if (cmd.wr_all) begin
      wr_be = '1;
    end else if (cmd.wr_one) begin
      wr_be = 8'(1) << pin_q[2:0];
    end
  end

  // Bit b of the byte belongs to entry 7-b of the row; unwritten entries read as zero
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_next[b] = rd_vld[7-b] && (phase < rd_data[(7-b)*BYTE_W +: BYTE_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= REG_COUNT_RST;
      step_max  <= STEP_MAX_RST;
      phase     <= '0;
      for (int r = 0; r < MAX_REGISTERS; r++) begin
        row_vld[r] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_REG_COUNT: reg_count <= cfg_data[REGCNT_W-1:0];
          CFG_STEP_MAX:  step_max  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.phase_adv) begin
        phase <= (phase < step_max) ? phase + 8'd1 : '0;
      end
      if (cmd.wr_one || cmd.wr_all) begin
        row_vld[wr_row] <= row_vld[wr_row] | wr_be;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pin_q  <= in_pin;
      duty_q <= in_duty;
    end
    for (int i = 0; i < 8; i++) begin
      if (wr_be[i]) begin
        mem[wr_row][i*BYTE_W +: BYTE_W] <= duty_q;
      end
    end
    if (cmd.rd) begin
      rd_data <= mem[row];
      rd_vld  <= row_vld[row];
    end
    if (cmd.emit) begin
      out_byte <= byte_next;
    end
  end

endmodule

// ===== hw/rtl/srpwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// srpwm_ctrl
// Operation sequencer: row sweeps, read pipeline flags and output valid.
// ----------------------------------------------------------------------------
`include "shift_register_pwm_generator_defines.svh"

module srpwm_ctrl
  import srpwm_pkg::*;
#(
  parameter int MAX_REGISTERS = MAX_REGISTERS_DEF,
  parameter int ROW_W         = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  output logic             out_valid,
  output logic             out_last,
  input  logic             out_ready,
  input  srpwm_status_t    status,
  output srpwm_cmd_t       cmd,
  output logic [ROW_W-1:0] row
);

  localparam int CNT_W = $clog2(MAX_REGISTERS + 1);

  typedef enum logic [1:0] {
    IDLE,
    SET_ONE,
    SET_ALL,
    TICK
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] left;
  logic             rd_valid;
  logic             rd_last;

  logic accept;
  logic out_free;
  logic issue;
  logic emit;
  logic tick_done;

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit      = rd_valid && out_free;
  assign issue     = (state == TICK) && (left != '0) && (!rd_valid || out_free);
  assign tick_done = (state == TICK) && (left == '0) && !rd_valid;
  assign row       = ROW_W'(left - CNT_W'(1));

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.wr_one    = (state == SET_ONE) && status.pin_ok;
    cmd.wr_all    = (state == SET_ALL) && (left != '0);
    cmd.rd        = issue;
    cmd.emit      = emit;
    cmd.phase_adv = tick_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      left      <= '0;
      rd_valid  <= 1'b0;
      rd_last   <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_last  <= rd_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (issue) begin
        rd_valid <= 1'b1;
        rd_last  <= (left == CNT_W'(1));
      end else if (emit) begin
        rd_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            case (in_op)
              OP_SET_ONE: state <= SET_ONE;
              OP_SET_ALL: begin
                left  <= CNT_W'(status.regs);
                state <= SET_ALL;
              end
              OP_TICK: begin
                left  <= CNT_W'(status.regs);
                state <= TICK;
              end
              default: state <= IDLE;
            endcase
          end
        end
        SET_ONE: state <= IDLE;
        SET_ALL: begin
          if (left == '0) begin
            state <= IDLE;
          end else begin
            left <= left - CNT_W'(1);
          end
        end
        TICK: begin
          if (issue) begin
            left <= left - CNT_W'(1);
          end
          if (tick_done) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `SRPWM_ASSERT_NOW(a_idle_pipe_empty, in_ready, !rd_valid, "read pending while idle")
  `SRPWM_ASSERT_NOW(a_phase_after_bytes, cmd.phase_adv, !emit && !issue,
                    "phase advanced with bytes in flight")
  `SRPWM_ASSERT_NOW(a_last_ends_sweep, emit && rd_last, left == '0,
                    "last byte emitted with rows left")
  `SRPWM_ASSERT_NEXT(a_issue_fills, issue, rd_valid, "issued read not held")

endmodule

// ===== hw/rtl/shift_register_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// shift_register_pwm_generator
// Multichannel PWM for a chain of 8-bit shift registers.
// ----------------------------------------------------------------------------
// Tick: each row is read into the read register and then compared into the output
//   byte, one byte per cycle while the output is not stalled; the next item is
//   taken once the last byte has left the read register.
// Set one pin writes a single entry; set all pins writes each row in use.
// The single read port of the duty store, one row of eight duties per cycle,
//   sets the byte rate. rst clears duties, phase and configuration at once.
module shift_register_pwm_generator
  import srpwm_pkg::*;
#(
  parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // op[1:0], pin[7:2], duty[15:8]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // shift_byte[7:0]
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

  srpwm_cmd_t       cmd;
  srpwm_status_t    status;
  logic [ROW_W-1:0] row;
  logic [BYTE_W-1:0] out_byte;

  srpwm_ctrl #(
    .MAX_REGISTERS (MAX_REGISTERS),
    .ROW_W         (ROW_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tdata[OP_W-1:0]),
    .out_valid (m_tvalid),
    .out_last  (m_tlast),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd),
    .row       (row)
  );

  srpwm_datapath #(
    .MAX_REGISTERS (MAX_REGISTERS),
    .ROW_W         (ROW_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_pin   (s_tdata[OP_W +: PIN_W]),
    .in_duty  (s_tdata[OP_W+PIN_W +: DUTY_W]),
    .cmd      (cmd),
    .row      (row),
    .status   (status),
    .out_byte (out_byte)
  );

  assign m_tdata = out_byte;

endmodule

// ===== tb/sv/tb_shift_register_pwm_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shift_register_pwm_generator
// Self-checking bench for the shift register PWM generator. Duty writes and
// ticks go in on the input stream. A scoreboard keeps its own duty table,
// phase and configuration, and predicts the bytes of every tick. Each output
// transfer is compared with the oldest pending byte. A directed pass comes
// first, then random traffic under several chain lengths and periods, with
// random stalls on both streams in all but one steady run.
// ----------------------------------------------------------------------------
module tb_shift_register_pwm_generator;
  import srpwm_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUIET_CYCLES   = 16;
  localparam int DRAIN_CYCLES   = 20;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // op[1:0], pin[7:2], duty[15:8]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // shift_byte[7:0]
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit steady_flow;
  int stall_cycles = 0;

  class pwm_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] shift_byte;
      logic              last_byte;
    } latch_byte_t;

    logic [DUTY_W-1:0]   duty_mem [MAX_REGISTERS_DEF * 8];
    logic [STEP_W-1:0]   phase;
    logic [STEP_W-1:0]   step_max;
    logic [REGCNT_W-1:0] reg_count;
    latch_byte_t         pending_bytes [$];
    int                  errors;

    function new();
      foreach (duty_mem[i]) duty_mem[i] = '0;
      phase     = '0;
      step_max  = STEP_MAX_RST;
      reg_count = REG_COUNT_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_REG_COUNT) begin
        reg_count = value[REGCNT_W-1:0];
      end else if (idx == CFG_STEP_MAX) begin
        step_max = value[STEP_W-1:0];
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [PIN_W-1:0] pin,
                            logic [DUTY_W-1:0] duty);
      int                regs;
      logic [BYTE_W-1:0] row_bits;
      // counts above the chain length act as a full chain
      regs = (reg_count > MAX_REGISTERS_DEF) ? MAX_REGISTERS_DEF : int'(reg_count);
      case (op)
        OP_SET_ONE: begin
          if (int'(pin) < regs * 8) duty_mem[pin] = duty;
        end
        OP_SET_ALL: begin
          for (int p = 0; p < regs * 8; p++) duty_mem[p] = duty;
        end
        OP_TICK: begin
          // highest register first; bit b carries pin 8*r+7-b
          for (int r = regs - 1; r >= 0; r--) begin
            for (int b = 0; b < 8; b++) row_bits[b] = (phase < duty_mem[r * 8 + 7 - b]);
            pending_bytes.push_back('{shift_byte: row_bits, last_byte: (r == 0)});
          end
          phase = (phase < step_max) ? phase + 1'b1 : '0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] shift_byte, logic last_byte);
      latch_byte_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected transfer, shift_byte actual %h last_byte actual %b",
                 $time, shift_byte, last_byte);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (shift_byte !== want.shift_byte) begin
        $display("%0t: shift_byte mismatch, expected %h actual %h",
                 $time, want.shift_byte, shift_byte);
        errors++;
      end
      if (last_byte !== want.last_byte) begin
        $display("%0t: last_byte mismatch, expected %b actual %b",
                 $time, want.last_byte, last_byte);
        errors++;
      end
    endfunction
  endclass

  pwm_scoreboard sb;

  shift_register_pwm_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // back-pressure on the output stream
  always @(negedge clk) begin
    m_tready <= steady_flow || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata[BYTE_W-1:0], m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [PIN_W-1:0] pin,
                           logic [DUTY_W-1:0] duty);
    while (!steady_flow && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {duty, pin, op};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, pin, duty);
    @(negedge clk);
  endtask

  // drop valid, let every pending byte out, then allow for silent work
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] count_word, logic [STEP_W-1:0] step);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_REG_COUNT;
    cfg_data <= count_word;
    @(posedge clk);
    sb.write_reg(CFG_REG_COUNT, count_word);
    @(negedge clk);
    cfg_addr <= CFG_STEP_MAX;
    cfg_data <= step;
    @(posedge clk);
    sb.write_reg(CFG_STEP_MAX, step);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [CFG_DATA_W-1:0] count_word, logic [STEP_W-1:0] step,
                              int target, bit steady);
    int                regs;
    int                pins;
    int                near_top;
    int                counted;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
    settle();
    configure(count_word, step);
    regs = (count_word[REGCNT_W-1:0] > MAX_REGISTERS_DEF) ? MAX_REGISTERS_DEF
                                                          : int'(count_word[REGCNT_W-1:0]);
    pins     = regs * 8;
    near_top = (int'(step) < 255) ? int'(step) + 1 : 255;
    steady_flow = steady;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      // half the duties sit close to the phase range so edges get exercised
      duty = ($urandom_range(0, 1) == 1) ? DUTY_W'($urandom)
                                         : DUTY_W'($urandom_range(0, near_top));
      pin  = PIN_W'($urandom);
      if (pick < 45) begin
        op = OP_TICK;
      end else if (pick < 82) begin
        op = OP_SET_ONE;
        if (pins > 0) pin = PIN_W'($urandom_range(0, pins - 1));
      end else if (pick < 92) begin
        op = OP_SET_ALL;
      end else if (pick < 96) begin
        op = OP_SPARE;
      end else begin
        op = OP_SET_ONE;  // any pin, often beyond the chain
      end
      send_item(op, pin, duty);
      counted++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    steady_flow = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: one register, full period
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_SET_ONE, 6'd7, 8'd255);
    send_item(OP_SET_ONE, 6'd0, 8'd2);
    send_item(OP_SET_ONE, 6'd8, 8'hC3);    // beyond the chain, ignored
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_SPARE, 6'd63, 8'd255);    // unused op, ignored
    send_item(OP_SET_ALL, 6'd0, 8'hAA);
    send_item(OP_TICK, 6'd0, 8'd0);

    // full chain, period of one; phase now lies above the new limit
    settle();
    configure(8'd8, 8'd0);
    send_item(OP_SET_ONE, 6'd63, 8'd255);
    send_item(OP_SET_ONE, 6'd0, 8'd0);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_TICK, 6'd0, 8'd0);

    // empty chain: writes land nowhere, ticks only advance the phase
    settle();
    configure(8'd0, 8'd255);
    send_item(OP_SET_ONE, 6'd0, 8'd9);
    send_item(OP_SET_ALL, 6'd0, 8'h55);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_TICK, 6'd0, 8'd0);

    // count above the chain length acts as the full chain
    settle();
    configure(8'd15, 8'd2);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_SET_ALL, 6'd0, 8'hFF);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_SET_ONE, 6'd42, 8'd1);
    send_item(OP_TICK, 6'd0, 8'd0);
    send_item(OP_TICK, 6'd0, 8'd0);

    random_phase(8'd8, 8'd255, 110, 1'b0);
    random_phase(8'd1, 8'd0, 40, 1'b0);
    random_phase(8'd3, 8'd7, 80, 1'b1);
    random_phase({4'($urandom), 4'd15}, 8'd3, 60, 1'b0);
    random_phase({4'($urandom), 4'd0}, 8'd5, 20, 1'b0);
    random_phase(8'd2, 8'd1, 50, 1'b0);
    random_phase(8'd5, STEP_W'($urandom_range(10, 40)), 60, 1'b0);
    random_phase({4'($urandom), 4'd8}, 8'd15, 50, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
